>>> hdl/cdtq_pkg.sv
package cdtq_pkg;

   // Field widths of one CAN frame and its release delay.
   localparam int DELAY_W   = 32;
   localparam int EXT_ID_W  = 29;
   localparam int STD_ID_W  = 11;
   localparam int DLC_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int BYTE_W    = 8;
   localparam int NUM_BYTES = PAYLOAD_W / BYTE_W;

   // Command codes carried by the cmd field of an item.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // One queue entry: the frame and the delay that gates its release.
   typedef struct packed {
      logic [DELAY_W-1:0]   delay;
      logic [EXT_ID_W-1:0]  ext_id;
      logic [STD_ID_W-1:0]  std_id;
      logic                 ide;
      logic                 rtr;
      logic [DLC_W-1:0]     dlc;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

endpackage

>>> hdl/cdtq_store.sv
module cdtq_store #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]     wr_addr,
   input  cdtq_pkg::entry_type                wr_entry,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]     rd_addr,
   output cdtq_pkg::entry_type                rd_entry
);
   import cdtq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_entry_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // Registered read port; a write to the address being read is forwarded so
   // the head copy never goes stale.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_entry_ff <= wr_entry;
      end else begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

>>> hdl/can_delayed_transmit_queue_top.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   cmd, delay_ticks, frame fields
// rsp_      out        rsp_valid/rsp_stall   released, dropped, frame fields
//
// One item is accepted per cycle while req_stall is low; each item yields one
// result, passing through the input register, then the result register.
// The pace is set by the head entry register, which the memory read port
// reloads every cycle with forwarding from the write port.
// Reset clears pointers, count, timer and valid flags; the frame memory is
// not cleared. A stalled result holds the input register, and req_stall rises.
module can_delayed_transmit_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [cdtq_pkg::DELAY_W-1:0]        req_delay_ticks,
   input  logic [cdtq_pkg::EXT_ID_W-1:0]       req_ext_id,
   input  logic [cdtq_pkg::STD_ID_W-1:0]       req_std_id,
   input  logic                                req_ide,
   input  logic                                req_rtr,
   input  logic [cdtq_pkg::DLC_W-1:0]          req_dlc,
   input  logic [cdtq_pkg::PAYLOAD_W-1:0]      req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_released,
   output logic                                rsp_dropped,
   output logic [cdtq_pkg::EXT_ID_W-1:0]       rsp_out_ext_id,
   output logic [cdtq_pkg::STD_ID_W-1:0]       rsp_out_std_id,
   output logic                                rsp_out_ide,
   output logic                                rsp_out_rtr,
   output logic [cdtq_pkg::DLC_W-1:0]          rsp_out_dlc,
   output logic [cdtq_pkg::PAYLOAD_W-1:0]      rsp_out_payload
);
   import cdtq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   // Input register.
   logic      in_valid_ff, in_valid_in;
   logic      in_cmd_ff;
   entry_type in_entry_ff;

   // Queue state.
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DELAY_W-1:0] elapsed_ff, elapsed_in;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   logic                 out_released_ff, out_released_in;
   logic                 out_dropped_ff, out_dropped_in;
   entry_type            out_entry_ff, out_entry_in;

   logic                 advance;
   logic                 accept;
   logic                 push_ok;
   logic                 release_now;
   logic [DELAY_W-1:0]   elapsed_inc;
   logic [PAYLOAD_W-1:0] masked_payload;
   entry_type            push_entry;
   entry_type            head_entry;

   // Handshake: the stored item moves on when the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Bytes at positions of dlc or above are cleared before storage.
   always_comb begin
      masked_payload = req_payload;
      for (int i = 0; i < NUM_BYTES; i++) begin
         if (!(DLC_W'(i) < req_dlc)) begin
            masked_payload[i*BYTE_W +: BYTE_W] = '0;
         end
      end
   end

   // Input register capture.
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff           <= req_cmd;
         in_entry_ff.delay   <= req_delay_ticks;
         in_entry_ff.ext_id  <= req_ext_id;
         in_entry_ff.std_id  <= req_std_id;
         in_entry_ff.ide     <= req_ide;
         in_entry_ff.rtr     <= req_rtr;
         in_entry_ff.dlc     <= req_dlc;
         in_entry_ff.payload <= masked_payload;
      end
   end

   assign push_entry = in_entry_ff;

   // Push and release decisions for the item in the input register.
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign push_ok     = advance && (in_cmd_ff == CMD_PUSH) && (count_ff != FULL_CNT);
   assign release_now = advance && (in_cmd_ff == CMD_TICK) && (count_ff != '0)
                        && (elapsed_inc >= head_entry.delay);

   // Next queue state.
   always_comb begin
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      if (push_ok) begin
         wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         count_in  = count_ff + 1'b1;
         if (count_ff == '0) begin
            elapsed_in = '0;
         end
      end else if (advance && (in_cmd_ff == CMD_TICK)) begin
         elapsed_in = elapsed_inc;
         if (release_now) begin
            elapsed_in = '0;
            rd_idx_in  = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
            count_in   = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff  <= '0;
         rd_idx_ff  <= '0;
         count_ff   <= '0;
         elapsed_ff <= '0;
      end else begin
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Frame memory; its read port always follows the next head index.
   cdtq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (push_ok),
      .wr_addr  (wr_idx_ff),
      .wr_entry (push_entry),
      .rd_addr  (rd_idx_in),
      .rd_entry (head_entry)
   );

   // Result register contents.
   always_comb begin
      out_valid_in    = in_valid_ff || (out_valid_ff && rsp_stall);
      out_released_in = release_now;
      out_dropped_in  = advance && (in_cmd_ff == CMD_PUSH) && (count_ff == FULL_CNT);
      out_entry_in    = '0;
      if (release_now) begin
         out_entry_in = head_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_released_ff <= out_released_in;
         out_dropped_ff  <= out_dropped_in;
         out_entry_ff    <= out_entry_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_released    = out_released_ff;
   assign rsp_dropped     = out_dropped_ff;
   assign rsp_out_ext_id  = out_entry_ff.ext_id;
   assign rsp_out_std_id  = out_entry_ff.std_id;
   assign rsp_out_ide     = out_entry_ff.ide;
   assign rsp_out_rtr     = out_entry_ff.rtr;
   assign rsp_out_dlc     = out_entry_ff.dlc;
   assign rsp_out_payload = out_entry_ff.payload;

endmodule
